/* rtl/core/smooth_window_jet_2d_core_macros.svh */
// Assertion macros used by the checker file of the window jet core.
`ifndef SMOOTH_WINDOW_JET_2D_CORE_MACROS_SVH
`define SMOOTH_WINDOW_JET_2D_CORE_MACROS_SVH

// Implication checked in the same cycle, disabled during reset.
`define SWJ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("window jet core assertion failed");

// Implication checked in the next cycle, disabled during reset.
`define SWJ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("window jet core assertion failed");

`endif

/* rtl/core/swj_pkg.sv */
// ----------------------------------------------------------------------------
// swj_pkg: shared types, constants and fixed-point helpers
// Holds the configuration and jet types and the rounding and saturation
// functions used by the axis and product stages.
// ----------------------------------------------------------------------------
package swj_pkg;

	localparam int unsigned FRAC_BITS = 16;
	localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	localparam logic [22:0] RST_PLATEAU = 23'd65536;
	localparam logic [22:0] RST_RAMP = 23'd32768;
	localparam logic [31:0] RST_INV = 32'd131072;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_PLATEAU = 2'd0,
		REG_RAMP    = 2'd1,
		REG_INV     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [22:0] h;
		logic [22:0] e;
		logic [31:0] a;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] j0;
		logic signed [31:0] j1;
		logic signed [31:0] j2;
		logic signed [31:0] j3;
	} jet_t;

	// Round half up and shift right by s bits (floor division).
	function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] p,
		input int unsigned s);
		return (p + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// Fixed-point product with rounding.
	function automatic logic signed [63:0] mulq(input logic signed [63:0] x,
		input logic signed [63:0] y);
		return rnd_sh(x * y, FRAC_BITS);
	endfunction

	// Saturate to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > S32_MAX) r = S32_MAX;
		if (v < S32_MIN) r = S32_MIN;
		return r[31:0];
	endfunction

endpackage

/* rtl/core/swj_axis.sv */
// ----------------------------------------------------------------------------
// swj_axis: one-axis window jet pipeline
// Nine register stages from coordinate to value and scaled derivatives.
// ----------------------------------------------------------------------------
module swj_axis (
	input  logic                clk,
	input  logic                en,
	input  swj_pkg::cfg_t       cfg,
	input  logic signed [23:0]  coord,
	output swj_pkg::jet_t       jet
);

	typedef enum logic [1:0] {M_ZERO, M_RISE, M_FLAT, M_FALL} mode_t;

	localparam logic signed [63:0] ONE = swj_pkg::ONE_Q;

	mode_t mode_c, mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6, mode_s7, mode_s8;
	logic signed [25:0] xs, hs, es, d_c, d_s1;
	logic signed [63:0] a64, t_c, s_c;
	logic signed [17:0] t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic signed [17:0] u_s3, u_s4, u_s5, u_s6, w_s3, w_s4;
	logic signed [27:0] acc_s4, acc_s5, acc_s6, acc_s7, accf_s8;
	logic signed [17:0] w2_s4, w3_s5, w4_s5, tw3_s6;
	logic signed [19:0] m7_s5;
	logic signed [63:0] u64_s4, g1_c, g3_c, g2_c;
	logic signed [21:0] g1_s6, g3_s6, g2_s7;
	logic signed [31:0] j1_s7, j1_s8, j3a_s7, j2a_s8, j3b_s8;
	logic               fall_s5, fall_s6;

	// Region decode and ramp offset.
	always_comb begin
		xs = 26'(coord);
		hs = $signed({3'b000, cfg.h});
		es = $signed({3'b000, cfg.e});
		a64 = $signed({32'd0, cfg.a});
		if (xs <= -hs - es || xs >= hs + es) mode_c = M_ZERO;
		else if (xs < es - hs) mode_c = M_RISE;
		else if (xs < hs - es) mode_c = M_FLAT;
		else mode_c = M_FALL;
		d_c = (mode_c == M_RISE) ? xs + hs : xs - hs;
	end

	// Ramp parameter, clamped to plus or minus one.
	always_comb begin
		t_c = swj_pkg::mulq(64'(d_s1), a64);
		if (t_c > ONE) t_c = ONE;
		if (t_c < -ONE) t_c = -ONE;
	end

	// Sign-adjusted derivative polynomials.
	always_comb begin
		u64_s4 = 64'(u_s4);
		g1_c = swj_pkg::rnd_sh(64'sd315 * 64'(w4_s5), 8);
		g3_c = swj_pkg::rnd_sh(64'sd105 * 64'(m7_s5), 6);
		g2_c = swj_pkg::rnd_sh(64'sd315 * 64'(tw3_s6), 6);
		if (fall_s5) begin
			g1_c = -g1_c;
			g3_c = -g3_c;
		end
		if (fall_s6) begin
			g2_c = -g2_c;
		end
	end

	assign fall_s5 = (mode_s5 == M_FALL);
	assign fall_s6 = (mode_s6 == M_FALL);

	// Window value from the last Horner product.
	always_comb begin
		s_c = ONE / 2 + swj_pkg::rnd_sh(64'(accf_s8), 8);
		if (s_c < 0) s_c = 0;
		if (s_c > ONE) s_c = ONE;
		if (mode_s8 == M_FALL) s_c = ONE - s_c;
	end

	// Pipeline registers.
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode_c;
			d_s1 <= d_c;

			mode_s2 <= mode_s1;
			t_s2 <= t_c[17:0];

			mode_s3 <= mode_s2;
			t_s3 <= t_s2;
			u_s3 <= 18'(swj_pkg::mulq(64'(t_s2), 64'(t_s2)));
			w_s3 <= 18'(swj_pkg::mulq(64'(t_s2), 64'(t_s2)) - ONE);

			mode_s4 <= mode_s3;
			t_s4 <= t_s3;
			u_s4 <= u_s3;
			w_s4 <= w_s3;
			acc_s4 <= 28'(swj_pkg::mulq(64'sd35 * ONE, 64'(u_s3)) - 64'sd180 * ONE);
			w2_s4 <= 18'(swj_pkg::mulq(64'(w_s3), 64'(w_s3)));

			mode_s5 <= mode_s4;
			t_s5 <= t_s4;
			u_s5 <= u_s4;
			acc_s5 <= 28'(swj_pkg::mulq(64'(acc_s4), u64_s4) + 64'sd378 * ONE);
			w3_s5 <= 18'(swj_pkg::mulq(64'(w2_s4), 64'(w_s4)));
			w4_s5 <= 18'(swj_pkg::mulq(64'(w2_s4), 64'(w2_s4)));
			m7_s5 <= 20'(swj_pkg::mulq(64'(w2_s4), 64'sd7 * u64_s4 - ONE));

			mode_s6 <= mode_s5;
			t_s6 <= t_s5;
			u_s6 <= u_s5;
			acc_s6 <= 28'(swj_pkg::mulq(64'(acc_s5), 64'(u_s5)) - 64'sd420 * ONE);
			tw3_s6 <= 18'(swj_pkg::mulq(64'(t_s5), 64'(w3_s5)));
			g1_s6 <= g1_c[21:0];
			g3_s6 <= g3_c[21:0];

			mode_s7 <= mode_s6;
			t_s7 <= t_s6;
			acc_s7 <= 28'(swj_pkg::mulq(64'(acc_s6), 64'(u_s6)) + 64'sd315 * ONE);
			g2_s7 <= g2_c[21:0];
			j1_s7 <= swj_pkg::sat32(swj_pkg::mulq(64'(g1_s6), a64));
			j3a_s7 <= swj_pkg::sat32(swj_pkg::mulq(64'(g3_s6), a64));

			mode_s8 <= mode_s7;
			accf_s8 <= 28'(swj_pkg::mulq(64'(acc_s7), 64'(t_s7)));
			j1_s8 <= j1_s7;
			j2a_s8 <= swj_pkg::sat32(swj_pkg::mulq(64'(g2_s7), a64));
			j3b_s8 <= swj_pkg::sat32(swj_pkg::mulq(64'(j3a_s7), a64));

			// Final stage: region override of the ramp jet.
			case (mode_s8)
				M_ZERO: begin
					jet <= '0;
				end
				M_FLAT: begin
					jet.j0 <= 32'(ONE);
					jet.j1 <= '0;
					jet.j2 <= '0;
					jet.j3 <= '0;
				end
				default: begin
					jet.j0 <= s_c[31:0];
					jet.j1 <= j1_s8;
					jet.j2 <= swj_pkg::sat32(swj_pkg::mulq(64'(j2a_s8), a64));
					jet.j3 <= swj_pkg::sat32(swj_pkg::mulq(64'(j3b_s8), a64));
				end
			endcase
		end
	end

endmodule

/* rtl/core/swj_prod.sv */
// ----------------------------------------------------------------------------
// swj_prod: cross products of the two axis jets
// Forms the ten saturated products and zeroes the result outside the window.
// ----------------------------------------------------------------------------
module swj_prod (
	input  logic           clk,
	input  logic           en,
	input  swj_pkg::jet_t  jx,
	input  swj_pkg::jet_t  jy,
	output logic           in_window,
	output logic [319:0]   terms
);

	logic         in_c;
	logic [319:0] t_c;

	// Products, packed value first.
	always_comb begin
		in_c = (jx.j0 != 0) && (jy.j0 != 0);
		t_c[31:0]    = swj_pkg::sat32(swj_pkg::mulq(64'(jx.j0), 64'(jy.j0)));
		t_c[63:32]   = swj_pkg::sat32(swj_pkg::mulq(64'(jx.j1), 64'(jy.j0)));
		t_c[95:64]   = swj_pkg::sat32(swj_pkg::mulq(64'(jx.j0), 64'(jy.j1)));
		t_c[127:96]  = swj_pkg::sat32(swj_pkg::mulq(64'(jx.j2), 64'(jy.j0)));
		t_c[159:128] = swj_pkg::sat32(swj_pkg::mulq(64'(jx.j1), 64'(jy.j1)));
		t_c[191:160] = swj_pkg::sat32(swj_pkg::mulq(64'(jx.j0), 64'(jy.j2)));
		t_c[223:192] = swj_pkg::sat32(swj_pkg::mulq(64'(jx.j3), 64'(jy.j0)));
		t_c[255:224] = swj_pkg::sat32(swj_pkg::mulq(64'(jx.j2), 64'(jy.j1)));
		t_c[287:256] = swj_pkg::sat32(swj_pkg::mulq(64'(jx.j1), 64'(jy.j2)));
		t_c[319:288] = swj_pkg::sat32(swj_pkg::mulq(64'(jx.j0), 64'(jy.j3)));
		if (!in_c) t_c = '0;
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			in_window <= in_c;
			terms <= t_c;
		end
	end

endmodule

/* rtl/core/smooth_window_jet_2d_core.sv */
// An input transaction passes through the axis pipelines and the product register.
// Throughput: one point per cycle; the whole pipeline holds while the output waits.
// Depth is set by the chain of dependent fixed-point products per axis.
// Reset clears valid bits and loads default configuration registers.
// ----------------------------------------------------------------------------
// smooth_window_jet_2d_core: 2D smooth window with third-order jet
// Two axis pipelines feed a product stage; results leave on a stream port.
// ----------------------------------------------------------------------------
module smooth_window_jet_2d_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // x_coord, y_coord
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [319:0] m_tdata,   // value_xy, dx, dy, dxx, dxy, dyy, dxxx, dxxy, dxyy, dyyy
	output logic         m_tuser,   // inside_res
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int DEPTH = 10;

	swj_pkg::cfg_t cfg_q;
	swj_pkg::jet_t jx, jy;
	logic [DEPTH-1:0] vld_q;
	logic en;

	assign cfg_ready = 1'b1;
	assign en = !vld_q[DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.h <= swj_pkg::RST_PLATEAU;
			cfg_q.e <= swj_pkg::RST_RAMP;
			cfg_q.a <= swj_pkg::RST_INV;
		end else if (cfg_valid) begin
			case (cfg_index)
				swj_pkg::REG_PLATEAU: cfg_q.h <= cfg_data[22:0];
				swj_pkg::REG_RAMP:    cfg_q.e <= cfg_data[22:0];
				swj_pkg::REG_INV:     cfg_q.a <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits that travel with the pipeline stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	swj_axis u_ax (.clk, .en, .cfg(cfg_q), .coord(s_tdata[23:0]), .jet(jx));
	swj_axis u_ay (.clk, .en, .cfg(cfg_q), .coord(s_tdata[47:24]), .jet(jy));
	swj_prod u_prod (.clk, .en, .jx, .jy, .in_window(m_tuser), .terms(m_tdata));

endmodule

/* rtl/core/swj_checker.sv */
// ----------------------------------------------------------------------------
// swj_checker: port-level checks of the window jet core
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
`include "smooth_window_jet_2d_core_macros.svh"

module swj_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [319:0] m_tdata,
	input logic         m_tuser
);

	// A stalled result holds.
	`SWJ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// A result outside the window carries all-zero terms.
	`SWJ_ASSERT_NOW(a_zero, m_tvalid && !m_tuser, m_tdata == '0)
	// A stalled output stops the input side.
	`SWJ_ASSERT_NOW(a_stall, m_tvalid && !m_tready, !s_tready)

endmodule

bind smooth_window_jet_2d_core swj_checker u_chk (.*);
